// ===== hw/rtl/mbq_pkg.sv =====
// Shared types, constants and helpers for the message block queue.
// No dependencies; imported by the top level and the testbench.
package mbq_pkg;

	localparam int NUM_BLOCKS      = 16;
	localparam int MAX_BLOCK_BYTES = 8;

	localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
	localparam int RING_AW   = IDX_W + 1;
	localparam int ACTION_W  = 3;
	localparam int HANDLE_W  = 4;
	localparam int PAYLOAD_W = 64;
	localparam int SIZE_W    = 4;
	localparam int STATUS_W  = 2;
	localparam int BB_W      = 4;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [ACTION_W-1:0] ACT_SEND   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RECV   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_HSEND  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_HRECV  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_FLUSH  = 3'd6;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNAVAIL   = 2'd2;

	localparam logic RING_FREE = 1'b0;
	localparam logic RING_MSG  = 1'b1;

	localparam logic           REG_BLOCK_BYTES = 1'b0;
	localparam logic [BB_W-1:0] BB_RESET       = 4'd8;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [HANDLE_W-1:0]  out_handle;
		logic [PAYLOAD_W-1:0] out_payload;
		logic                 no_block;
		logic                 queue_empty;
		logic                 pool_full;
		logic                 last;
	} res_t;

	// low n bytes set
	function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
		logic [PAYLOAD_W-1:0] m;
		m = '0;
		for (int b = 0; b < PAYLOAD_W / 8; b++) begin
			m[8*b +: 8] = (SIZE_W'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(NUM_BLOCKS - 1)) ? '0 : i + 1'b1;
	endfunction

	// free ring contents after reset: N-1 down to 0
	function automatic logic [HANDLE_W-1:0] free_init(input logic [IDX_W-1:0] i);
		return HANDLE_W'(NUM_BLOCKS - 1) - HANDLE_W'(i);
	endfunction

endpackage

// ===== hw/rtl/mbq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the handle rings and the block store.
module mbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/message_block_queue.sv =====
// Message block queue top level: free pool and message ring over two RAMs.
// Depends on mbq_pkg and mbq_ram.
//
// A fixed pool of NUM_BLOCKS blocks, each one 64-bit payload word, with every
// handle sitting in either the free ring or the message ring. Both rings share
// one RAM (free ring in the lower half, message ring in the upper half); the
// payloads live in a second RAM. One command beat is taken on the s_ side at a
// time and produces its result beat(s) on the m_ side, held in an output
// register so the next command is accepted while a result waits. Free, handle
// send, errors and the empty flush go straight to the result; alloc first reads
// the free ring; send, receive and handle receive read a ring, then the block,
// and send and receive then write back. A flush of k queued blocks does one ring
// read, one block read and one result per block. The sequencer holds
// s_tready low until the command's last result is in the output register.
// The free ring powers up as N-1 down to 0 through per-entry valid bits, so no
// clearing pass is needed after reset. Config (block_bytes at address 0) must
// only be written while idle.
module message_block_queue
	import mbq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// command stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // handle[3:0], payload[67:4], size[71:68]
	input  logic [ACTION_W-1:0]   s_tuser,   // action[2:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_handle[3:0], out_payload[67:4],
	                                         // queue_empty[68], pool_full[69], zero[71:70]
	output logic [OUT_USER_W-1:0] m_tuser,   // status[1:0], no_block[2]
	output logic                  m_tlast,   // last result of the command
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a command
	localparam logic [1:0] ST_RING  = 2'd1;  // ring read data valid
	localparam logic [1:0] ST_STORE = 2'd2;  // block read data valid
	localparam logic [1:0] ST_EMIT  = 2'd3;  // result waiting for the output register

	logic [1:0] state_q, state_d;

	// latched command
	logic [ACTION_W-1:0]  op_q, op_d;
	logic [PAYLOAD_W-1:0] pay_q, pay_d;
	logic [SIZE_W-1:0]    size_q, size_d;
	logic [HANDLE_W-1:0]  h_q, h_d;      // handle fetched from a ring

	// ring pointers and counts
	logic [IDX_W-1:0] fh_q, fh_d, ft_q, ft_d, mh_q, mh_d, mt_q, mt_d;
	logic [CNT_W-1:0] fc_q, fc_d, mc_q, mc_d;
	logic [NUM_BLOCKS-1:0] fvalid_q, fvalid_d;

	res_t res_q, res_d;
	res_t out_q, out_d;
	logic m_valid_q, m_valid_d;

	logic [BB_W-1:0] bb_q;

	// RAM ports
	logic                  ring_we;
	logic [RING_AW-1:0]    ring_waddr, ring_raddr;
	logic [HANDLE_W-1:0]   ring_wdata, ring_rdata, ring_h;
	logic                  store_we;
	logic [IDX_W-1:0]      store_waddr, store_raddr;
	logic [PAYLOAD_W-1:0]  store_wdata, store_rdata;

	// read-side tags for valid-bit substitution
	logic             rd_fsel_s1, rd_fvalid_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic                 s_accept;
	logic [HANDLE_W-1:0]  in_handle;
	logic [PAYLOAD_W-1:0] in_payload;
	logic [SIZE_W-1:0]    in_size;
	logic [BB_W-1:0]      lim;
	logic                 cfg_wr;

	assign in_handle  = s_tdata[HANDLE_W-1:0];
	assign in_payload = s_tdata[HANDLE_W +: PAYLOAD_W];
	assign in_size    = s_tdata[HANDLE_W + PAYLOAD_W +: SIZE_W];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// effective byte limit
	assign lim = (bb_q < BB_W'(MAX_BLOCK_BYTES)) ? bb_q : BB_W'(MAX_BLOCK_BYTES);

	// never-written free ring entries read as their reset handle
	assign ring_h = (rd_fsel_s1 && !rd_fvalid_s1) ? free_init(rd_idx_s1) : ring_rdata;

	mbq_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(2 * NUM_BLOCKS)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	mbq_ram #(
		.WIDTH(PAYLOAD_W),
		.DEPTH(NUM_BLOCKS)
	) u_store_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(store_wdata),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	// result with no block attached
	function automatic res_t blank_res(input logic [STATUS_W-1:0] st, input logic qe,
	                                   input logic pf);
		res_t r;
		r.status      = st;
		r.out_handle  = '0;
		r.out_payload = '0;
		r.no_block    = 1'b1;
		r.queue_empty = qe;
		r.pool_full   = pf;
		r.last        = 1'b1;
		return r;
	endfunction

	function automatic res_t blk_res(input logic [HANDLE_W-1:0] h,
	                                 input logic [PAYLOAD_W-1:0] p,
	                                 input logic qe, input logic pf, input logic lst);
		res_t r;
		r.status      = STAT_OK;
		r.out_handle  = h;
		r.out_payload = p;
		r.no_block    = 1'b0;
		r.queue_empty = qe;
		r.pool_full   = pf;
		r.last        = lst;
		return r;
	endfunction

	always_comb begin
		logic               too_big;
		logic [CNT_W-1:0]   fc_n;
		logic [PAYLOAD_W-1:0] m;

		too_big = (in_size > lim);
		fc_n    = fc_q;
		m       = '0;

		state_d  = state_q;
		op_d     = op_q;
		pay_d    = pay_q;
		size_d   = size_q;
		h_d      = h_q;
		fh_d     = fh_q;
		ft_d     = ft_q;
		fc_d     = fc_q;
		mh_d     = mh_q;
		mt_d     = mt_q;
		mc_d     = mc_q;
		fvalid_d = fvalid_q;
		res_d    = res_q;
		out_d    = out_q;

		m_valid_d = m_valid_q;
		if (m_valid_q && m_tready) begin
			m_valid_d = 1'b0;
		end

		ring_we     = 1'b0;
		ring_waddr  = '0;
		ring_wdata  = '0;
		ring_raddr  = '0;
		store_we    = 1'b0;
		store_waddr = '0;
		store_wdata = '0;
		store_raddr = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					op_d    = s_tuser;
					pay_d   = in_payload;
					size_d  = in_size;
					state_d = ST_EMIT;
					unique case (s_tuser)
						ACT_SEND, ACT_ALLOC: begin
							if (too_big) begin
								res_d = blank_res(STAT_TOO_LARGE, mc_q == '0, fc_q == '0);
							end else if (fc_q == '0) begin
								res_d = blank_res(STAT_UNAVAIL, mc_q == '0, 1'b1);
							end else begin
								ring_raddr = {RING_FREE, fh_q};
								state_d    = ST_RING;
							end
						end
						ACT_RECV: begin
							if (too_big) begin
								res_d = blank_res(STAT_TOO_LARGE, mc_q == '0, fc_q == '0);
							end else if (mc_q == '0) begin
								res_d = blank_res(STAT_UNAVAIL, 1'b1, fc_q == '0);
							end else begin
								ring_raddr = {RING_MSG, mh_q};
								state_d    = ST_RING;
							end
						end
						ACT_FREE: begin
							if (CNT_W'(in_handle) >= CNT_W'(NUM_BLOCKS) ||
							    fc_q >= CNT_W'(NUM_BLOCKS)) begin
								res_d = blank_res(STAT_UNAVAIL, mc_q == '0, fc_q == '0);
							end else begin
								ring_we          = 1'b1;
								ring_waddr       = {RING_FREE, ft_q};
								ring_wdata       = in_handle;
								fvalid_d[ft_q]   = 1'b1;
								ft_d             = ring_next(ft_q);
								fc_d             = fc_q + 1'b1;
								res_d = blk_res(in_handle, '0, mc_q == '0, 1'b0, 1'b1);
							end
						end
						ACT_HSEND: begin
							if (CNT_W'(in_handle) >= CNT_W'(NUM_BLOCKS) ||
							    mc_q >= CNT_W'(NUM_BLOCKS)) begin
								res_d = blank_res(STAT_UNAVAIL, mc_q == '0, fc_q == '0);
							end else begin
								store_we    = 1'b1;
								store_waddr = IDX_W'(in_handle);
								store_wdata = in_payload & byte_mask(lim);
								ring_we     = 1'b1;
								ring_waddr  = {RING_MSG, mt_q};
								ring_wdata  = in_handle;
								mt_d        = ring_next(mt_q);
								mc_d        = mc_q + 1'b1;
								res_d = blk_res(in_handle, '0, 1'b0, fc_q == '0, 1'b1);
							end
						end
						ACT_HRECV: begin
							if (mc_q == '0) begin
								res_d = blank_res(STAT_UNAVAIL, 1'b1, fc_q == '0);
							end else begin
								ring_raddr = {RING_MSG, mh_q};
								state_d    = ST_RING;
							end
						end
						ACT_FLUSH: begin
							if (mc_q == '0) begin
								res_d = blank_res(STAT_OK, 1'b1, fc_q == '0);
							end else begin
								ring_raddr = {RING_MSG, mh_q};
								state_d    = ST_RING;
							end
						end
						default: begin
							// unused action code: no-op result
							res_d = blank_res(STAT_OK, mc_q == '0, fc_q == '0);
						end
					endcase
				end
			end

			ST_RING: begin
				h_d = ring_h;
				if (op_q == ACT_ALLOC) begin
					fh_d    = ring_next(fh_q);
					fc_d    = fc_q - 1'b1;
					res_d   = blk_res(ring_h, '0, mc_q == '0, fc_d == '0, 1'b1);
					state_d = ST_EMIT;
				end else begin
					store_raddr = IDX_W'(ring_h);
					state_d     = ST_STORE;
				end
			end

			ST_STORE: begin
				state_d = ST_EMIT;
				unique case (op_q)
					ACT_SEND: begin
						// only the low size bytes are replaced
						m           = byte_mask(size_q);
						store_we    = 1'b1;
						store_waddr = IDX_W'(h_q);
						store_wdata = (store_rdata & ~m) | (pay_q & m);
						ring_we     = 1'b1;
						ring_waddr  = {RING_MSG, mt_q};
						ring_wdata  = h_q;
						fh_d        = ring_next(fh_q);
						fc_d        = fc_q - 1'b1;
						mt_d        = ring_next(mt_q);
						mc_d        = mc_q + 1'b1;
						res_d = blk_res(h_q, '0, 1'b0, fc_d == '0, 1'b1);
					end
					ACT_HRECV: begin
						mh_d  = ring_next(mh_q);
						mc_d  = mc_q - 1'b1;
						res_d = blk_res(h_q, store_rdata & byte_mask(lim), mc_d == '0,
						                fc_q == '0, 1'b1);
					end
					default: begin
						// receive and flush: dequeue, return to pool unless it is full
						mh_d = ring_next(mh_q);
						mc_d = mc_q - 1'b1;
						if (fc_q < CNT_W'(NUM_BLOCKS)) begin
							ring_we        = 1'b1;
							ring_waddr     = {RING_FREE, ft_q};
							ring_wdata     = h_q;
							fvalid_d[ft_q] = 1'b1;
							ft_d           = ring_next(ft_q);
							fc_n           = fc_q + 1'b1;
						end
						fc_d = fc_n;
						if (op_q == ACT_FLUSH) begin
							res_d = blk_res(h_q, store_rdata & byte_mask(lim), 1'b1,
							                fc_n == '0, mc_d == '0);
						end else begin
							res_d = blk_res(h_q, store_rdata & byte_mask(size_q),
							                mc_d == '0, fc_n == '0, 1'b1);
						end
					end
				endcase
			end

			ST_EMIT: begin
				if (!m_valid_q || m_tready) begin
					out_d     = res_q;
					m_valid_d = 1'b1;
					if (op_q == ACT_FLUSH && !res_q.last) begin
						// next queued block
						ring_raddr = {RING_MSG, mh_q};
						state_d    = ST_RING;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fh_q      <= '0;
			ft_q      <= '0;
			fc_q      <= CNT_W'(NUM_BLOCKS);
			mh_q      <= '0;
			mt_q      <= '0;
			mc_q      <= '0;
			fvalid_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			fh_q      <= fh_d;
			ft_q      <= ft_d;
			fc_q      <= fc_d;
			mh_q      <= mh_d;
			mt_q      <= mt_d;
			mc_q      <= mc_d;
			fvalid_q  <= fvalid_d;
			m_valid_q <= m_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		pay_q  <= pay_d;
		size_q <= size_d;
		h_q    <= h_d;
		res_q  <= res_d;
		out_q  <= out_d;
		rd_fsel_s1   <= (ring_raddr[IDX_W] == RING_FREE);
		rd_fvalid_s1 <= fvalid_q[ring_raddr[IDX_W-1:0]];
		rd_idx_s1    <= ring_raddr[IDX_W-1:0];
	end

	// register port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q <= BB_RESET;
		end else if (cfg_wr && paddr[2] == REG_BLOCK_BYTES) begin
			bb_q <= pwdata[BB_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BLOCK_BYTES) ? {{(PDATA_W - BB_W){1'b0}}, bb_q} : '0;

	// result beat
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_q.pool_full, out_q.queue_empty, out_q.out_payload,
	                   out_q.out_handle};
	assign m_tuser  = {out_q.no_block, out_q.status};
	assign m_tlast  = out_q.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for message_block_queue: command beats in, result beats out.
// Depends on mbq_pkg and the message_block_queue RTL; the block's behavior is
// predicted inside the scoreboard class below.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mbq_pkg::*;

	// action code the block does not define; it must answer with an empty ok beat
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
	localparam logic [PADDR_W-1:0]  BB_ADDR    = PADDR_W'(4 * int'(REG_BLOCK_BYTES));
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_RUN = 41;     // random commands per phase
	localparam int DRAIN_CYCLES  = 64;     // longer than a full flush of every block
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		logic [ACTION_W-1:0]  action;
		logic [HANDLE_W-1:0]  handle;
		logic [PAYLOAD_W-1:0] payload;
		logic [SIZE_W-1:0]    size;
	} cmd_t;

	// Tracks free ring, message ring and block payloads; predicts result beats
	// per accepted command and checks the beats coming out of the block.
	class block_queue_scoreboard;
		logic [HANDLE_W-1:0]  pool_ring[NUM_BLOCKS];
		logic [HANDLE_W-1:0]  msg_ring[NUM_BLOCKS];
		logic [PAYLOAD_W-1:0] payload_mem[NUM_BLOCKS];
		int pool_head, pool_tail, pool_cnt;
		int msg_head, msg_tail, msg_cnt;
		int bytes_cfg;
		res_t due_results[$];
		int mismatches;

		function new();
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				pool_ring[i]   = HANDLE_W'(NUM_BLOCKS - 1 - i);
				msg_ring[i]    = '0;
				payload_mem[i] = '0;
			end
			pool_head  = 0;
			pool_tail  = 0;
			pool_cnt   = NUM_BLOCKS;
			msg_head   = 0;
			msg_tail   = 0;
			msg_cnt    = 0;
			bytes_cfg  = int'(BB_RESET);
			mismatches = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%s", msg);
		endfunction

		function int limit();
			return (bytes_cfg < MAX_BLOCK_BYTES) ? bytes_cfg : MAX_BLOCK_BYTES;
		endfunction

		function logic [PAYLOAD_W-1:0] lane_mask(int n);
			if (n >= 8)
				return '1;
			return (64'd1 << (8 * n)) - 64'd1;
		endfunction

		function logic [HANDLE_W-1:0] pool_pop();
			logic [HANDLE_W-1:0] h;
			h = pool_ring[pool_head];
			pool_head = (pool_head + 1) % NUM_BLOCKS;
			pool_cnt--;
			return h;
		endfunction

		// a full pool silently drops the handle
		function void pool_push(logic [HANDLE_W-1:0] h);
			if (pool_cnt >= NUM_BLOCKS)
				return;
			pool_ring[pool_tail] = h;
			pool_tail = (pool_tail + 1) % NUM_BLOCKS;
			pool_cnt++;
		endfunction

		function logic [HANDLE_W-1:0] msg_pop();
			logic [HANDLE_W-1:0] h;
			h = msg_ring[msg_head];
			msg_head = (msg_head + 1) % NUM_BLOCKS;
			msg_cnt--;
			return h;
		endfunction

		function void msg_push(logic [HANDLE_W-1:0] h);
			msg_ring[msg_tail] = h;
			msg_tail = (msg_tail + 1) % NUM_BLOCKS;
			msg_cnt++;
		endfunction

		function res_t beat(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] h,
		                    logic [PAYLOAD_W-1:0] p, logic nb);
			res_t r;
			r = '0;
			r.status      = st;
			r.out_handle  = nb ? '0 : h;
			r.out_payload = nb ? '0 : p;
			r.no_block    = nb;
			return r;
		endfunction

		function void note_command(cmd_t c);
			res_t batch[$];
			res_t r;
			logic [HANDLE_W-1:0]  h;
			logic [PAYLOAD_W-1:0] m;
			int lim;
			lim = limit();
			case (c.action)
				ACT_SEND: begin
					if (c.size > lim) begin
						batch.push_back(beat(STAT_TOO_LARGE, '0, '0, 1'b1));
					end else if (pool_cnt == 0) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						// only the low size bytes of the block change
						m = lane_mask(c.size);
						h = pool_pop();
						payload_mem[h] = (payload_mem[h] & ~m) | (c.payload & m);
						msg_push(h);
						batch.push_back(beat(STAT_OK, h, '0, 1'b0));
					end
				end
				ACT_RECV: begin
					if (c.size > lim) begin
						batch.push_back(beat(STAT_TOO_LARGE, '0, '0, 1'b1));
					end else if (msg_cnt == 0) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						h = msg_pop();
						batch.push_back(beat(STAT_OK, h, payload_mem[h] & lane_mask(c.size), 1'b0));
						pool_push(h);
					end
				end
				ACT_ALLOC: begin
					if (c.size > lim) begin
						batch.push_back(beat(STAT_TOO_LARGE, '0, '0, 1'b1));
					end else if (pool_cnt == 0) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						h = pool_pop();
						batch.push_back(beat(STAT_OK, h, '0, 1'b0));
					end
				end
				ACT_FREE: begin
					if (int'(c.handle) >= NUM_BLOCKS || pool_cnt >= NUM_BLOCKS) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						pool_push(c.handle);
						batch.push_back(beat(STAT_OK, c.handle, '0, 1'b0));
					end
				end
				ACT_HSEND: begin
					if (int'(c.handle) >= NUM_BLOCKS || msg_cnt >= NUM_BLOCKS) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						payload_mem[c.handle] = c.payload & lane_mask(lim);
						msg_push(c.handle);
						batch.push_back(beat(STAT_OK, c.handle, '0, 1'b0));
					end
				end
				ACT_HRECV: begin
					if (msg_cnt == 0) begin
						batch.push_back(beat(STAT_UNAVAIL, '0, '0, 1'b1));
					end else begin
						h = msg_pop();
						batch.push_back(beat(STAT_OK, h, payload_mem[h] & lane_mask(lim), 1'b0));
					end
				end
				ACT_FLUSH: begin
					if (msg_cnt == 0) begin
						batch.push_back(beat(STAT_OK, '0, '0, 1'b1));
					end else begin
						while (msg_cnt > 0) begin
							h = msg_pop();
							batch.push_back(beat(STAT_OK, h, payload_mem[h] & lane_mask(lim), 1'b0));
							pool_push(h);
						end
					end
				end
				default: begin
					batch.push_back(beat(STAT_OK, '0, '0, 1'b1));
				end
			endcase
			// ring flags reflect the state after the whole command
			foreach (batch[k]) begin
				r = batch[k];
				r.queue_empty = (msg_cnt == 0);
				r.pool_full   = (pool_cnt == 0);
				r.last        = (k == batch.size() - 1);
				due_results.push_back(r);
			end
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected result beat: st=%0d h=%0d p=%h nb=%b qe=%b pf=%b last=%b",
				               a.status, a.out_handle, a.out_payload, a.no_block,
				               a.queue_empty, a.pool_full, a.last));
				return;
			end
			e = due_results.pop_front();
			if (a.status !== e.status || a.out_handle !== e.out_handle ||
			    a.out_payload !== e.out_payload || a.no_block !== e.no_block ||
			    a.queue_empty !== e.queue_empty || a.pool_full !== e.pool_full ||
			    a.last !== e.last)
				flag($sformatf({"result mismatch: exp st=%0d h=%0d p=%h nb=%b qe=%b pf=%b last=%b",
				                " / got st=%0d h=%0d p=%h nb=%b qe=%b pf=%b last=%b"},
				               e.status, e.out_handle, e.out_payload, e.no_block,
				               e.queue_empty, e.pool_full, e.last,
				               a.status, a.out_handle, a.out_payload, a.no_block,
				               a.queue_empty, a.pool_full, a.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // handle[3:0], payload[67:4], size[71:68]
	logic [ACTION_W-1:0]   s_tuser;    // action[2:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;    // out_handle[3:0], out_payload[67:4],
	                                   // queue_empty[68], pool_full[69], zero[71:70]
	logic [OUT_USER_W-1:0] m_tuser;    // status[1:0], no_block[2]
	logic m_tlast;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	block_queue_scoreboard sb;
	int idle_pct;     // chance per cycle that the command side holds back
	int stall_pct;    // chance per cycle that the result side stalls
	int cycles;
	res_t seen;

	message_block_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cycle watchdog; covers the worst case of full flushes under heavy stalls
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	// result monitor: a beat counts at the rising edge with tvalid and tready high
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen             = '0;
			seen.status      = m_tuser[1:0];
			seen.no_block    = m_tuser[2];
			seen.out_handle  = m_tdata[3:0];
			seen.out_payload = m_tdata[67:4];
			seen.queue_empty = m_tdata[68];
			seen.pool_full   = m_tdata[69];
			seen.last        = m_tlast;
			sb.check_result(seen);
		end
	end

	// Entered and left at a falling edge. Random hold-off first, then the beat
	// is held until the block takes it; valid stays high for a back-to-back beat.
	task automatic drive_command(cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {c.size, c.payload, c.handle};
		s_tuser  = c.action;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic send_cmd(logic [ACTION_W-1:0] a, logic [HANDLE_W-1:0] h,
	                        logic [PAYLOAD_W-1:0] p, logic [SIZE_W-1:0] sz);
		cmd_t c;
		c.action  = a;
		c.handle  = h;
		c.payload = p;
		c.size    = sz;
		drive_command(c);
	endtask

	// wait until every predicted beat has come out, then leave the command bus idle
	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read_check(logic [PADDR_W-1:0] addr, int exp_val);
		psel    = 1'b1;
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== PDATA_W'(exp_val))
			sb.flag($sformatf("register read mismatch: exp %h got %h", PDATA_W'(exp_val), prdata));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Random command; fill spells push blocks into the message ring and drain
	// the pool, drain spells do the opposite, so both rings hit empty and full.
	function automatic cmd_t random_command(bit filling);
		cmd_t c;
		int r;
		int lim;
		lim = sb.limit();
		r = $urandom_range(99);
		if (filling) begin
			if (r < 35)      c.action = ACT_SEND;
			else if (r < 60) c.action = ACT_ALLOC;
			else if (r < 70) c.action = ACT_HSEND;
			else if (r < 78) c.action = ACT_RECV;
			else if (r < 85) c.action = ACT_HRECV;
			else if (r < 92) c.action = ACT_FREE;
			else if (r < 97) c.action = ACT_FLUSH;
			else             c.action = ACT_UNUSED;
		end else begin
			if (r < 30)      c.action = ACT_RECV;
			else if (r < 45) c.action = ACT_HRECV;
			else if (r < 70) c.action = ACT_FREE;
			else if (r < 78) c.action = ACT_FLUSH;
			else if (r < 88) c.action = ACT_SEND;
			else if (r < 93) c.action = ACT_ALLOC;
			else if (r < 98) c.action = ACT_HSEND;
			else             c.action = ACT_UNUSED;
		end
		c.handle = HANDLE_W'($urandom_range(NUM_BLOCKS - 1, 0));
		r = $urandom_range(99);
		if (r < 10)      c.payload = '1;
		else if (r < 15) c.payload = '0;
		else             c.payload = {$urandom, $urandom};
		// mostly legal sizes, some just past the limit, a few anywhere in the field
		r = $urandom_range(99);
		if (r < 80)
			c.size = SIZE_W'($urandom_range(lim, 0));
		else if (r < 95 && lim < MAX_BLOCK_BYTES)
			c.size = SIZE_W'($urandom_range(MAX_BLOCK_BYTES, lim + 1));
		else
			c.size = SIZE_W'($urandom_range(15, 0));
		return c;
	endfunction

	task automatic random_commands(int n);
		bit filling;
		filling = $urandom_range(1);
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 19)
				filling = !filling;
			drive_command(random_command(filling));
		end
	endtask

	initial begin
		int bb;
		sb        = new();
		cycles    = 0;
		idle_pct  = 0;
		stall_pct = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_read_check(BB_ADDR, int'(BB_RESET));

		// --- directed part, reset limit of 8 bytes, no idling ---
		// empty message ring and full pool corners
		send_cmd(ACT_FREE, 4'd5, '0, 4'd0);
		send_cmd(ACT_RECV, 4'd0, '0, 4'd0);
		send_cmd(ACT_HRECV, 4'd0, '0, 4'd0);
		send_cmd(ACT_FLUSH, 4'd0, '0, 4'd0);
		send_cmd(ACT_UNUSED, 4'd15, '1, 4'd15);
		// write every block in full before anything can read one back;
		// this also fills the message ring to the brim
		for (int h = 0; h < NUM_BLOCKS; h++)
			send_cmd(ACT_HSEND, HANDLE_W'(h),
			         (h == 0) ? '1 : (h == NUM_BLOCKS - 1) ? '0 : {$urandom, $urandom},
			         4'd0);
		send_cmd(ACT_HSEND, 4'd3, {$urandom, $urandom}, 4'd0);   // ring full
		// sizes past the limit
		send_cmd(ACT_SEND, 4'd0, '1, 4'd9);
		send_cmd(ACT_RECV, 4'd0, '0, 4'd15);
		send_cmd(ACT_ALLOC, 4'd0, '0, 4'd9);
		// flush of a full ring: sixteen beats, pool already full so all are dropped
		send_cmd(ACT_FLUSH, 4'd0, '0, 4'd0);

		random_commands(ITEMS_PER_RUN);

		// --- random phases over limit settings and idle patterns ---
		for (int p = 1; p <= 4; p++) begin
			settle();
			case (p)
				1: bb = 1;
				2: bb = $urandom_range(MAX_BLOCK_BYTES - 1, 2);
				3: bb = MAX_BLOCK_BYTES;
				default: bb = $urandom_range(MAX_BLOCK_BYTES, 1);
			endcase
			apb_write(BB_ADDR, PDATA_W'(bb));
			sb.bytes_cfg = bb;
			apb_read_check(BB_ADDR, bb);
			case (p)
				1: begin
					idle_pct  = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 82;
				end
				3: begin
					idle_pct  = 33;
					stall_pct = 33;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			random_commands(ITEMS_PER_RUN);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
